### hw/rtl/glcd_pkg.sv
// ----------------------------------------------------------------------------
// glcd_pkg
// Shared types, constants and helper functions for the dual-chip graphic LCD
// bus controller: command codes, instruction bytes, payload structs.
// ----------------------------------------------------------------------------
package glcd_pkg;

	// Panel geometry
	localparam int PAGE_COUNT   = 8;
	localparam int HALF_COLUMNS = 64;
	localparam int PAGE_W       = (PAGE_COUNT > 8) ? $clog2(PAGE_COUNT) : 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int SLOT_COUNT   = 3;

	// Command codes
	typedef enum logic [2:0] {
		CMD_SET_ADDR   = 3'd0,
		CMD_WRITE_DATA = 3'd1,
		CMD_READ_DATA  = 3'd2,
		CMD_START_LINE = 3'd3,
		CMD_POWER      = 3'd4
	} cmd_e;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_DISABLE = 2'd0,
		CFG_SETUP   = 2'd1,
		CFG_HOLD    = 2'd2
	} cfg_idx_e;

	localparam logic [7:0] DISABLE_RESET = 8'd5;
	localparam logic [7:0] SETUP_RESET   = 8'd5;
	localparam logic [7:0] HOLD_RESET    = 8'd25;

	// Controller instruction bytes
	localparam logic [7:0] INSTR_COLUMN = 8'h40;
	localparam logic [7:0] INSTR_PAGE   = 8'hB8;
	localparam logic [7:0] INSTR_START  = 8'hC0;
	localparam logic [7:0] INSTR_POWER  = 8'h3E;
	localparam logic [2:0] PAGE_MASK    = 3'h7;

	// Back-end strobe sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISABLE,
		ST_SETUP,
		ST_HOLD,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [6:0] column;
		logic [2:0] page;
		logic [7:0] write_byte;
		logic [5:0] start_line;
		logic       power_on;
		logic [7:0] bus_in;
	} cmd_item_t;

	typedef struct packed {
		logic       target_half;
		logic       reg_select;
		logic       read_not_write;
		logic [7:0] bus_byte;
		logic [7:0] read_value;
		logic       last;
	} result_t;

	// One command's worth of bus transactions
	typedef struct packed {
		logic [1:0]                 count;
		result_t [SLOT_COUNT-1:0]   slot;
	} job_t;

	typedef struct packed {
		logic       en;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	// Build one transaction record
	function automatic result_t make_res(logic half, logic rs, logic rw,
		logic [7:0] bus, logic [7:0] rd);
		result_t r;
		r.target_half    = half;
		r.reg_select     = rs;
		r.read_not_write = rw;
		r.bus_byte       = bus;
		r.read_value     = rd;
		r.last           = 1'b0;
		return r;
	endfunction

	// Column reduced onto the panel width (few compare/subtract steps)
	function automatic logic [6:0] col_mod(logic [6:0] col);
		logic [7:0] v;
		v = {1'b0, col};
		for (int i = 0; i < 8; i++) begin
			if (v >= 8'(2 * HALF_COLUMNS))
				v = v - 8'(2 * HALF_COLUMNS);
		end
		return v[6:0];
	endfunction

	// Next page after a wrap, modulo the page count
	function automatic logic [PAGE_W-1:0] page_next(logic [PAGE_W-1:0] pg);
		logic [PAGE_W:0] v;
		v = {1'b0, pg} + (PAGE_W+1)'(1);
		for (int i = 0; i < 8; i++) begin
			if (v >= (PAGE_W+1)'(PAGE_COUNT))
				v = v - (PAGE_W+1)'(PAGE_COUNT);
		end
		return v[PAGE_W-1:0];
	endfunction

endpackage

### hw/rtl/glcd_front.sv
// ----------------------------------------------------------------------------
// glcd_front
// Accepts commands, tracks the global cursor and expands each known command into
// a job of one to three bus transactions.
// ----------------------------------------------------------------------------
module glcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  glcd_pkg::cmd_item_t cmd_data,
	output logic                push_valid,
	input  logic                push_ready,
	output glcd_pkg::job_t      push_data
);

	localparam logic [7:0] HALF_C  = 8'(glcd_pkg::HALF_COLUMNS);
	localparam logic [7:0] COLS2_C = 8'(2 * glcd_pkg::HALF_COLUMNS);
	localparam logic [6:0] HALF7_C = 7'(glcd_pkg::HALF_COLUMNS);

	logic [6:0]                  col_q, col_d;
	logic [glcd_pkg::PAGE_W-1:0] page_q, page_d;
	logic                        accept;
	glcd_pkg::job_t              job;

	assign cmd_ready  = push_ready;
	assign accept     = cmd_valid && cmd_ready;
	assign push_valid = accept && (job.count != 2'd0);
	assign push_data  = job;

	// Command decode and cursor update
	always_comb begin
		logic [6:0]                  set_col;
		logic                        set_half;
		logic [6:0]                  chip_col;
		logic [7:0]                  inc;
		logic                        data_half;
		logic [glcd_pkg::PAGE_W-1:0] wrap_page;
		job       = '0;
		col_d     = col_q;
		page_d    = page_q;
		set_col   = glcd_pkg::col_mod(cmd_data.column);
		set_half  = {1'b0, set_col} >= HALF_C;
		chip_col  = set_half ? (set_col - HALF7_C) : set_col;
		inc       = {1'b0, col_q} + 8'd1;
		data_half = {1'b0, col_q} >= HALF_C;
		wrap_page = glcd_pkg::page_next(page_q);
		unique case (glcd_pkg::cmd_e'(cmd_data.cmd)) inside
			glcd_pkg::CMD_SET_ADDR: begin
				col_d  = set_col;
				page_d = glcd_pkg::PAGE_W'(cmd_data.page);
				job.count = 2'd2;
				job.slot[0] = glcd_pkg::make_res(set_half, 1'b0, 1'b0,
					glcd_pkg::INSTR_COLUMN | {2'b00, chip_col[5:0]}, 8'h00);
				job.slot[1] = glcd_pkg::make_res(set_half, 1'b0, 1'b0,
					glcd_pkg::INSTR_PAGE | {5'b0, cmd_data.page & glcd_pkg::PAGE_MASK},
					8'h00);
			end
			glcd_pkg::CMD_WRITE_DATA, glcd_pkg::CMD_READ_DATA: begin
				if (cmd_data.cmd == glcd_pkg::CMD_WRITE_DATA)
					job.slot[0] = glcd_pkg::make_res(data_half, 1'b1, 1'b0,
						cmd_data.write_byte, 8'h00);
				else
					job.slot[0] = glcd_pkg::make_res(data_half, 1'b1, 1'b1,
						8'h00, cmd_data.bus_in);
				job.count = 2'd1;
				col_d = inc[6:0];
				// crossing into the right chip
				if (inc == HALF_C) begin
					job.count = 2'd3;
					job.slot[1] = glcd_pkg::make_res(1'b1, 1'b0, 1'b0,
						glcd_pkg::INSTR_COLUMN, 8'h00);
					job.slot[2] = glcd_pkg::make_res(1'b1, 1'b0, 1'b0,
						glcd_pkg::INSTR_PAGE | {5'b0, page_q[2:0]}, 8'h00);
				end else if (inc >= COLS2_C) begin
					// end of line: wrap column, next page, back to left chip
					col_d  = 7'd0;
					page_d = wrap_page;
					job.count = 2'd3;
					job.slot[1] = glcd_pkg::make_res(1'b0, 1'b0, 1'b0,
						glcd_pkg::INSTR_COLUMN, 8'h00);
					job.slot[2] = glcd_pkg::make_res(1'b0, 1'b0, 1'b0,
						glcd_pkg::INSTR_PAGE | {5'b0, wrap_page[2:0]}, 8'h00);
				end
			end
			glcd_pkg::CMD_START_LINE: begin
				job.count = 2'd2;
				job.slot[0] = glcd_pkg::make_res(1'b0, 1'b0, 1'b0,
					glcd_pkg::INSTR_START | {2'b00, cmd_data.start_line}, 8'h00);
				job.slot[1] = glcd_pkg::make_res(1'b1, 1'b0, 1'b0,
					glcd_pkg::INSTR_START | {2'b00, cmd_data.start_line}, 8'h00);
			end
			glcd_pkg::CMD_POWER: begin
				job.count = 2'd2;
				job.slot[0] = glcd_pkg::make_res(1'b0, 1'b0, 1'b0,
					glcd_pkg::INSTR_POWER | {7'b0, cmd_data.power_on}, 8'h00);
				job.slot[1] = glcd_pkg::make_res(1'b1, 1'b0, 1'b0,
					glcd_pkg::INSTR_POWER | {7'b0, cmd_data.power_on}, 8'h00);
			end
			default: begin
				// unknown command: dropped, cursor unchanged
			end
		endcase
		// mark the final transaction of the command
		if (job.count != 2'd0)
			job.slot[job.count - 2'd1].last = 1'b1;
	end

	// Cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			page_q <= '0;
		end else if (accept) begin
			col_q  <= col_d;
			page_q <= page_d;
		end
	end

endmodule

### hw/rtl/glcd_queue.sv
// ----------------------------------------------------------------------------
// glcd_queue
// Short job queue that decouples command decode from the strobe sequencer.
// ----------------------------------------------------------------------------
module glcd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  glcd_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output glcd_pkg::job_t pop_data
);

	localparam int DEPTH = glcd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	glcd_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

### hw/rtl/glcd_back.sv
// ----------------------------------------------------------------------------
// glcd_back
// Strobe sequencer: plays each job's transactions through the disable,
// setup and hold windows and hands them to the result register.
// ----------------------------------------------------------------------------
module glcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  glcd_pkg::cfg_wr_t cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  glcd_pkg::job_t    pop_data,
	output logic              res_valid,
	input  logic              res_ready,
	output glcd_pkg::result_t res_data
);

	glcd_pkg::back_state_t state_q, state_d;
	logic [7:0]            disable_q, setup_q, hold_q;
	logic [7:0]            cnt_q;
	logic [1:0]            idx_q;
	glcd_pkg::job_t        job_q;
	logic                  out_valid_q;
	glcd_pkg::result_t     out_data_q;
	logic                  slot_free;
	logic                  take_job, load_out, cnt_clr, job_end;

	assign slot_free = !out_valid_q || res_ready;
	assign job_end   = idx_q == (job_q.count - 2'd1);
	assign res_valid = out_valid_q;
	assign res_data  = out_data_q;
	assign pop_ready = take_job;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disable_q <= glcd_pkg::DISABLE_RESET;
			setup_q   <= glcd_pkg::SETUP_RESET;
			hold_q    <= glcd_pkg::HOLD_RESET;
		end else if (cfg.en) begin
			unique case (glcd_pkg::cfg_idx_e'(cfg.index))
				glcd_pkg::CFG_DISABLE: disable_q <= cfg.data;
				glcd_pkg::CFG_SETUP:   setup_q   <= cfg.data;
				glcd_pkg::CFG_HOLD:    hold_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			glcd_pkg::ST_IDLE:    if (pop_valid) state_d = glcd_pkg::ST_DISABLE;
			glcd_pkg::ST_DISABLE: if (cnt_q == disable_q) state_d = glcd_pkg::ST_SETUP;
			glcd_pkg::ST_SETUP:   if (cnt_q == setup_q) state_d = glcd_pkg::ST_HOLD;
			glcd_pkg::ST_HOLD:    if (cnt_q == hold_q) state_d = glcd_pkg::ST_DONE;
			glcd_pkg::ST_DONE: begin
				if (slot_free)
					state_d = job_end ? glcd_pkg::ST_IDLE : glcd_pkg::ST_DISABLE;
			end
			default: state_d = glcd_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		take_job = 1'b0;
		load_out = 1'b0;
		cnt_clr  = 1'b1;
		unique case (state_q)
			glcd_pkg::ST_IDLE:    take_job = pop_valid;
			glcd_pkg::ST_DISABLE: cnt_clr  = cnt_q == disable_q;
			glcd_pkg::ST_SETUP:   cnt_clr  = cnt_q == setup_q;
			glcd_pkg::ST_HOLD:    cnt_clr  = cnt_q == hold_q;
			glcd_pkg::ST_DONE:    load_out = slot_free;
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glcd_pkg::ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_clr ? 8'd0 : cnt_q + 8'd1;
			if (take_job)
				idx_q <= 2'd0;
			else if (load_out)
				idx_q <= idx_q + 2'd1;
		end
	end

	// Current job payload
	always_ff @(posedge clk) begin
		if (take_job)
			job_q <= pop_data;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= job_q.slot[idx_q];
	end

	// Checks
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == glcd_pkg::ST_DONE))
		else $error("result register loaded outside DONE");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take_job |=> state_q == glcd_pkg::ST_DISABLE && idx_q == 2'd0)
		else $error("job taken without starting strobe sequence");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != glcd_pkg::ST_IDLE |-> job_q.count != 2'd0 && idx_q < job_q.count)
		else $error("transaction index beyond job");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && job_end |-> job_q.slot[idx_q].last)
		else $error("final transaction of job not marked last");

endmodule

### hw/rtl/dual_chip_glcd_bus_controller.sv
// ----------------------------------------------------------------------------
// dual_chip_glcd_bus_controller
// Command front end, job queue and enable-strobe sequencer for a 128x64
// graphic LCD made of two 64-column controller chips.
// ----------------------------------------------------------------------------
// Each known command yields 1 to 3 bus transactions; each passes through the
// disable, setup and hold windows of the strobe sequencer (set by the disable,
// setup and hold registers) and waits in DONE for the result register; the
// sequencer returns to idle between commands.
// Commands are accepted while the two-entry job queue has room.
// Reset: cursor to column 0 page 0, timing registers to 5/5/25, queue empty.
module dual_chip_glcd_bus_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  glcd_pkg::cmd_item_t cmd_data,
	output logic                res_valid,
	input  logic                res_ready,
	output glcd_pkg::result_t   res_data,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata
);

	logic              push_valid, push_ready;
	glcd_pkg::job_t    push_data;
	logic              pop_valid, pop_ready;
	glcd_pkg::job_t    pop_data;
	glcd_pkg::cfg_wr_t cfg;

	assign cfg.en    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_wdata;

	// Decode and cursor tracking
	glcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_data   (cmd_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Job queue
	glcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Strobe sequencer and result register
	glcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule
